// ----- hw/rtl/mba_pkg.sv -----
// ----------------------------------------------------------------------------
// mba_pkg: shared types and constants of the block averager
// Sample, sum and count widths, the queued item and the back-end states.
// ----------------------------------------------------------------------------
package mba_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 8;
  localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS;

  // divider runs one quotient bit per step over the whole sum
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  localparam count_t COUNT_MAX         = '1;
  localparam count_t MIN_SAMPLES_RESET = count_t'(63);

  // one conversion sequence as it travels through the queue
  typedef struct packed {
    sample_t [CHANNELS-1:0] samples;
    logic                   busy;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } back_state_t;

endpackage

// ----- hw/rtl/mba_front.sv -----
// ----------------------------------------------------------------------------
// mba_front: input side of the block averager
// Takes input beats into a short queue; the back end drains it at its pace.
// ----------------------------------------------------------------------------
module mba_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mba_pkg::item_t in_item,
  output logic          q_valid,
  output mba_pkg::item_t q_item,
  input  logic          q_pop
);
  import mba_pkg::*;

  item_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  fill;
  logic                  push;
  logic                  pop;

  // handshake and head of queue
  assign in_stall = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/mba_back.sv -----
// ----------------------------------------------------------------------------
// mba_back: accumulate, divide and publish
// Keeps the channel sums and count, runs a bit-serial divider per channel
// on publish and holds the result in the output register.
// ----------------------------------------------------------------------------
module mba_back (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  input  mba_pkg::item_t                              q_item,
  output logic                                        q_pop,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  mba_pkg::count_t                             cfg_data,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output mba_pkg::sample_t [mba_pkg::CHANNELS-1:0]    out_avg,
  output logic                                        out_updated
);
  import mba_pkg::*;

  back_state_t            state;
  back_state_t            state_next;

  count_t                 min_samples;
  count_t                 count;
  sum_t                   sums     [CHANNELS];
  sample_t                avgs     [CHANNELS];

  // divider lanes: dividend shifts out, quotient shifts in
  count_t                 divisor;
  count_t                 rem      [CHANNELS];
  sum_t                   dvd      [CHANNELS];
  count_t                 rem_next [CHANNELS];
  sum_t                   dvd_next [CHANNELS];
  logic [STEP_BITS-1:0]   step;
  sample_t [CHANNELS-1:0] pend;

  count_t                 need;
  logic                   out_free;
  logic                   publish;
  logic                   take_plain;
  logic                   take_publish;
  logic                   div_run;
  logic                   commit;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign need      = (min_samples == '0) ? count_t'(1) : min_samples;
  assign publish   = (count >= need) && !q_item.busy;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free && publish) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop        = 1'b0;
    take_plain   = 1'b0;
    take_publish = 1'b0;
    div_run      = 1'b0;
    commit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop        = q_valid && out_free;
        take_plain   = q_valid && out_free && !publish;
        take_publish = q_valid && out_free && publish;
      end
      ST_DIVIDE: div_run = 1'b1;
      ST_FINISH: commit  = out_free;
      default: ;
    endcase
  end

  // one restoring step per lane
  always_comb begin
    logic [COUNT_BITS:0] rem_sh;
    logic                ge;
    for (int c = 0; c < CHANNELS; c++) begin
      rem_sh      = {rem[c], dvd[c][SUM_BITS-1]};
      ge          = (rem_sh >= {1'b0, divisor});
      rem_next[c] = ge ? COUNT_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[COUNT_BITS-1:0];
      dvd_next[c] = {dvd[c][SUM_BITS-2:0], ge};
    end
  end

  // state register and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      min_samples <= MIN_SAMPLES_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        min_samples <= cfg_data;
      end
    end
  end

  // accumulator, count and published averages
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c] <= '0;
        avgs[c] <= '0;
      end
    end else if (take_plain && count != COUNT_MAX) begin
      count <= count + 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c] <= sums[c] + SUM_BITS'(q_item.samples[c]);
      end
    end else if (commit) begin
      // cleared on publish, then this beat's samples go in
      count <= count_t'(1);
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c] <= SUM_BITS'(pend[c]);
        avgs[c] <= dvd[c][SAMPLE_BITS-1:0];
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (take_publish) begin
      divisor <= count;
      step    <= '0;
      pend    <= q_item.samples;
      for (int c = 0; c < CHANNELS; c++) begin
        dvd[c] <= sums[c];
        rem[c] <= '0;
      end
    end else if (div_run) begin
      step <= step + 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        dvd[c] <= dvd_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_plain || commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_plain) begin
      out_updated <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        out_avg[c] <= avgs[c];
      end
    end else if (commit) begin
      out_updated <= 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
        out_avg[c] <= dvd[c][SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/multichannel_block_averager.sv -----
// ----------------------------------------------------------------------------
// multichannel_block_averager: four-channel block-average decimator
// Sums conversion sequences per channel and publishes truncated averages
// once the configured minimum count is reached and the reader is idle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one conversion sequence per
//   beat: sample_ch0..3 and reader_busy. A two-beat queue sits in front, so
//   in_stall rises only when that queue is full.
//   Output channel (out_valid / out_stall) returns one beat per input beat:
//   the current published averages and updated.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data) writes
//   min_samples; cfg_ready is always high. Write it only while idle.
//   A non-publishing beat passes a queue slot and the output register. A
//   publishing beat runs the bit-serial dividers, one quotient bit per cycle
//   over the 20-bit sums, then the finish state. Non-publishing beats go one
//   per cycle while out_stall is low; no beat is taken while a publish runs.
//   Reset clears sums, count and averages and sets min_samples to 63.
//   While out_stall is high the result holds in the output register; the
//   queue keeps taking input beats until it fills.
// ----------------------------------------------------------------------------
module multichannel_block_averager (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [11:0]              sample_ch0,
  input  logic [11:0]              sample_ch1,
  input  logic [11:0]              sample_ch2,
  input  logic [11:0]              sample_ch3,
  input  logic                     reader_busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [11:0]              average_ch0,
  output logic [11:0]              average_ch1,
  output logic [11:0]              average_ch2,
  output logic [11:0]              average_ch3,
  output logic                     updated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [7:0]               cfg_data
);
  import mba_pkg::*;

  item_t                  in_item;
  item_t                  q_item;
  logic                   q_valid;
  logic                   q_pop;
  sample_t [CHANNELS-1:0] out_avg;

  // pack the input beat
  assign in_item.samples[0] = sample_ch0;
  assign in_item.samples[1] = sample_ch1;
  assign in_item.samples[2] = sample_ch2;
  assign in_item.samples[3] = sample_ch3;
  assign in_item.busy       = reader_busy;

  mba_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mba_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_avg     (out_avg),
    .out_updated (updated)
  );

  // unpack the result beat
  assign average_ch0 = out_avg[0];
  assign average_ch1 = out_avg[1];
  assign average_ch2 = out_avg[2];
  assign average_ch3 = out_avg[3];

endmodule
